/* sv/assert_macros.svh */
// Assertion macros shared by the decoder RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, ignored while in reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition holds on every rising clock edge, including reset.
`define ASSERT_ALWAYS(label, clk, cond, msg) \
    label: assert property (@(posedge clk) (cond)) else $error(msg);

`endif

/* sv/gsfd_pkg.sv */
// Shared types, constants and functions for the gas sensor frame decoder.
// No dependencies; imported by gsfd_scale and gas_sensor_frame_decoder.
`default_nettype none

package gsfd_pkg;

    localparam int unsigned FRAME_BYTES = 12;
    localparam logic [3:0]  LAST_POS    = 4'(FRAME_BYTES - 1);
    localparam logic [7:0]  CRC_POLY    = 8'h31;
    localparam logic [7:0]  CRC_INIT    = 8'hFF;

    // Conversion constants: span = WHOLE * 65535 + FRAC
    localparam logic [15:0] TEMP_FRAC    = 16'd43930;
    localparam logic [1:0]  TEMP_WHOLE   = 2'd2;
    localparam logic [18:0] TEMP_OFFSET  = 19'd45000;
    localparam logic [15:0] HUMID_FRAC   = 16'd59465;
    localparam logic [1:0]  HUMID_WHOLE  = 2'd1;
    localparam logic [18:0] HUMID_OFFSET = 19'd6000;
    localparam logic [31:0] ROUND_BIAS   = 32'd32767;
    localparam logic [32:0] DIVISOR      = 33'd65535;

    localparam logic [1:0] WORD_CO2    = 2'd0;
    localparam logic [1:0] WORD_TEMP   = 2'd1;
    localparam logic [1:0] WORD_HUMID  = 2'd2;
    localparam logic [1:0] WORD_STATUS = 2'd3;

    typedef enum logic [1:0] {
        PH_HIGH = 2'd0,
        PH_LOW  = 2'd1,
        PH_CRC  = 2'd2
    } phase_t;

    typedef enum logic {
        CONV_TEMP  = 1'b0,
        CONV_HUMID = 1'b1
    } conv_kind_t;

    typedef struct packed {
        logic [1:0] word;
        phase_t     phase;
    } pos_info_t;

    // Split a byte position into word index and phase within the word.
    function automatic pos_info_t pos_decode(input logic [3:0] pos);
        pos_info_t info;
        case (pos)
            4'd0:    info = '{word: WORD_CO2,    phase: PH_HIGH};
            4'd1:    info = '{word: WORD_CO2,    phase: PH_LOW};
            4'd2:    info = '{word: WORD_CO2,    phase: PH_CRC};
            4'd3:    info = '{word: WORD_TEMP,   phase: PH_HIGH};
            4'd4:    info = '{word: WORD_TEMP,   phase: PH_LOW};
            4'd5:    info = '{word: WORD_TEMP,   phase: PH_CRC};
            4'd6:    info = '{word: WORD_HUMID,  phase: PH_HIGH};
            4'd7:    info = '{word: WORD_HUMID,  phase: PH_LOW};
            4'd8:    info = '{word: WORD_HUMID,  phase: PH_CRC};
            4'd9:    info = '{word: WORD_STATUS, phase: PH_HIGH};
            4'd10:   info = '{word: WORD_STATUS, phase: PH_LOW};
            4'd11:   info = '{word: WORD_STATUS, phase: PH_CRC};
            default: info = '{word: WORD_CO2,    phase: PH_HIGH};
        endcase
        return info;
    endfunction

    // Feed one byte into the CRC-8, MSB first.
    function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

/* sv/gsfd_scale.sv */
// Raw sensor word to milli-unit conversion: round(span * raw / 65535) - offset.
// Depends on gsfd_pkg for the conversion constants and kind selector.
`default_nettype none

module gsfd_scale
    import gsfd_pkg::*;
(
    input  wire logic               aclk,
    input  wire conv_kind_t         kind,
    input  wire logic               load,
    input  wire logic        [15:0] raw,
    output logic signed      [17:0] value
);

    logic [15:0] frac;
    logic [1:0]  whole;
    logic [18:0] offset;

    logic [31:0] prod_reg, prod_next;
    logic [15:0] raw_reg;
    logic [31:0] prod1_reg;
    logic [15:0] raw1_reg;
    logic [15:0] qest_reg, qest_next;
    logic [17:0] value_reg, value_next;

    logic [32:0] qsum;
    logic [32:0] rem;
    logic [15:0] quot;
    logic [18:0] whole_term;
    logic [18:0] sum19;

    always_comb begin
        case (kind)
            CONV_TEMP: begin
                frac   = TEMP_FRAC;
                whole  = TEMP_WHOLE;
                offset = TEMP_OFFSET;
            end
            CONV_HUMID: begin
                frac   = HUMID_FRAC;
                whole  = HUMID_WHOLE;
                offset = HUMID_OFFSET;
            end
            default: begin
                frac   = TEMP_FRAC;
                whole  = TEMP_WHOLE;
                offset = TEMP_OFFSET;
            end
        endcase
    end

    // Fractional part of the span, biased for rounding; stays below 65535^2.
    assign prod_next = 32'(32'(frac) * 32'(raw)) + ROUND_BIAS;

    // Quotient estimate by 65536 with one fold; low by at most one.
    assign qsum      = 33'(prod1_reg) + 33'(prod1_reg[31:16]);
    assign qest_next = qsum[31:16];

    always_ff @(posedge aclk) begin
        if (load) begin
            prod_reg <= prod_next;
            raw_reg  <= raw;
        end
        prod1_reg <= prod_reg;
        raw1_reg  <= raw_reg;
        qest_reg  <= qest_next;
        value_reg <= value_next;
    end

    // Correct the estimate, add the whole multiple of raw and drop the offset.
    always_comb begin
        rem        = 33'(prod1_reg) - (({17'b0, qest_reg} << 16) - 33'(qest_reg));
        quot       = (rem >= DIVISOR) ? qest_reg + 16'd1 : qest_reg;
        whole_term = 19'(19'(raw1_reg) * 19'(whole));
        sum19      = 19'(quot) + whole_term - offset;
        value_next = sum19[17:0];
    end

    assign value = signed'(value_reg);

endmodule

`default_nettype wire

/* sv/gas_sensor_frame_decoder.sv */
// Gas sensor frame decoder: 12-byte CRC-8 protected frames to one decoded word.
// Throughput one byte per cycle; result word valid in the cycle after the twelfth byte is accepted.
// Byte accept is blocked only while a result word waits and m_tready is low.
// Rate set by the byte-wide CRC and the two constant-divisor scale pipelines.
// aresetn (sync, active low) clears position, CRC, error flags and output valid.
// Depends on gsfd_pkg, gsfd_scale and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module gas_sensor_frame_decoder
    import gsfd_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input byte channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  wire logic [0:0]  s_tuser,   // [0] frame_start
    // decoded result channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata,   // [1:0] bad_word, [17:2] co2_ppm,
                                        // [35:18] temperature_mdegc,
                                        // [53:36] humidity_mpercent,
                                        // [69:54] status_word, [71:70] zero
    output logic [0:0]       m_tuser    // [0] result_code
);

    // frame tracking state
    logic [3:0]  pos_reg, pos_next;
    logic [7:0]  crc_reg, crc_next;
    logic [7:0]  high_reg, high_next;
    logic [15:0] co2_reg, co2_next;
    logic [15:0] status_reg, status_next;
    logic        fail_reg, fail_next;
    logic [1:0]  bad_reg, bad_next;

    // output word
    logic        m_tvalid_reg, m_tvalid_next;
    logic        m_code_reg;
    logic [1:0]  m_bad_reg;
    logic [15:0] m_co2_reg;
    logic [17:0] m_temp_reg;
    logic [17:0] m_humid_reg;
    logic [15:0] m_status_reg;

    logic        s_accept;
    logic [7:0]  rx_byte;
    logic        frame_start;
    logic [3:0]  pos_eff;
    logic        fail_eff;
    logic [1:0]  bad_eff;
    pos_info_t   info;
    logic        crc_bad;
    logic        fail_new;
    logic [1:0]  bad_new;
    logic        last_byte;
    logic        emit;
    logic [15:0] full_word;
    logic        load_temp;
    logic        load_humid;

    logic signed [17:0] temp_value;
    logic signed [17:0] humid_value;

    assign rx_byte     = s_tdata[7:0];
    assign frame_start = s_tuser[0];

    // Take a new byte whenever the output slot is free or being drained.
    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    // Restart on a start mark; treat an impossible position as byte 0.
    always_comb begin
        if (frame_start || (pos_reg > LAST_POS)) begin
            pos_eff = 4'd0;
        end else begin
            pos_eff = pos_reg;
        end
        fail_eff = frame_start ? 1'b0 : fail_reg;
        bad_eff  = frame_start ? 2'd0 : bad_reg;
    end

    assign info      = pos_decode(pos_eff);
    assign full_word = {high_reg, rx_byte};
    assign last_byte = (pos_eff == LAST_POS);
    assign emit      = s_accept && last_byte;

    // Record only the first failing word of the frame.
    assign crc_bad  = (info.phase == PH_CRC) && (crc_reg != rx_byte);
    assign fail_new = fail_eff || crc_bad;
    assign bad_new  = (crc_bad && !fail_eff) ? info.word : bad_eff;

    assign load_temp  = s_accept && (info.phase == PH_LOW) && (info.word == WORD_TEMP);
    assign load_humid = s_accept && (info.phase == PH_LOW) && (info.word == WORD_HUMID);

    always_comb begin
        pos_next    = pos_reg;
        crc_next    = crc_reg;
        high_next   = high_reg;
        co2_next    = co2_reg;
        status_next = status_reg;
        fail_next   = fail_reg;
        bad_next    = bad_reg;
        if (s_accept) begin
            case (info.phase)
                PH_HIGH: begin
                    crc_next  = crc8_feed(CRC_INIT, rx_byte);
                    high_next = rx_byte;
                end
                PH_LOW: begin
                    crc_next = crc8_feed(crc_reg, rx_byte);
                    if (info.word == WORD_CO2) begin
                        co2_next = full_word;
                    end
                    if (info.word == WORD_STATUS) begin
                        status_next = full_word;
                    end
                end
                default: begin
                end
            endcase
            if (last_byte) begin
                // wrap for the next frame and clear the error flags
                pos_next  = 4'd0;
                fail_next = 1'b0;
                bad_next  = 2'd0;
            end else begin
                pos_next  = pos_eff + 4'd1;
                fail_next = fail_new;
                bad_next  = bad_new;
            end
        end
    end

    // Hold the result word until taken; a new result may replace it as it drains.
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (emit) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= 4'd0;
            crc_reg      <= CRC_INIT;
            fail_reg     <= 1'b0;
            bad_reg      <= 2'd0;
            m_tvalid_reg <= 1'b0;
        end else begin
            pos_reg      <= pos_next;
            crc_reg      <= crc_next;
            fail_reg     <= fail_next;
            bad_reg      <= bad_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        high_reg   <= high_next;
        co2_reg    <= co2_next;
        status_reg <= status_next;
        if (emit) begin
            m_code_reg <= fail_new;
            if (fail_new) begin
                // drop the measurement fields on a bad frame
                m_bad_reg    <= bad_new;
                m_co2_reg    <= 16'd0;
                m_temp_reg   <= 18'd0;
                m_humid_reg  <= 18'd0;
                m_status_reg <= 16'd0;
            end else begin
                m_bad_reg    <= 2'd0;
                m_co2_reg    <= co2_reg;
                m_temp_reg   <= unsigned'(temp_value);
                m_humid_reg  <= unsigned'(humid_value);
                m_status_reg <= status_reg;
            end
        end
    end

    // Both scale pipelines settle before the last byte of a frame is accepted.
    gsfd_scale u_temp_scale (
        .aclk  (aclk),
        .kind  (CONV_TEMP),
        .load  (load_temp),
        .raw   (full_word),
        .value (temp_value)
    );

    gsfd_scale u_humid_scale (
        .aclk  (aclk),
        .kind  (CONV_HUMID),
        .load  (load_humid),
        .raw   (full_word),
        .value (humid_value)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_code_reg;
    assign m_tdata  = {2'b00, m_status_reg, m_humid_reg, m_temp_reg, m_co2_reg, m_bad_reg};

    `ASSERT_CLK(a_pos_in_frame, aclk, aresetn, pos_reg <= LAST_POS, "byte position left the frame")
    `ASSERT_CLK(a_stall_blocks_input, aclk, aresetn, (m_tvalid_reg && !m_tready) |-> !s_tready, "input taken while result stalled")
    `ASSERT_CLK(a_result_from_last, aclk, aresetn, $rose(m_tvalid_reg) |-> $past(emit), "result word without a last byte")
    `ASSERT_CLK(a_bad_frame_zeroed, aclk, aresetn, (m_tvalid_reg && m_code_reg) |-> (m_co2_reg == 16'd0 && m_status_reg == 16'd0), "bad frame carries data")
    `ASSERT_CLK(a_good_frame_no_index, aclk, aresetn, (m_tvalid_reg && !m_code_reg) |-> (m_bad_reg == 2'd0), "good frame reports a bad word")

endmodule

`default_nettype wire

/* bench/gas_sensor_frame_decoder_tb.sv */
// Self-checking bench for gas_sensor_frame_decoder: directed and random byte streams with
// a local decoder model that forecasts each decoded frame word and checks it on arrival.
// Depends on gsfd_pkg (types and constants) and the decoder RTL.
`timescale 1ns / 1ps

module gas_sensor_frame_decoder_tb;

    import gsfd_pkg::*;

    localparam longint TEMP_SPAN_MDEG  = 175000;
    localparam longint TEMP_BASE_MDEG  = 45000;
    localparam longint HUMID_SPAN_MPC  = 125000;
    localparam longint HUMID_BASE_MPC  = 6000;
    localparam int     TAIL_CYCLES     = 10;

    // one decoded frame as it leaves on the result channel
    typedef struct {
        logic               crc_error;
        logic [1:0]         bad_word;
        logic signed [15:0] co2_ppm;
        logic signed [17:0] temp_mdegc;
        logic signed [17:0] humid_mpct;
        logic [15:0]        status;
    } sensor_reading_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;   // [7:0] rx_byte
    logic [0:0]  s_tuser  = 1'b0;    // [0] frame_start
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;            // [1:0] bad_word, [17:2] co2_ppm, [35:18] temperature,
                                     // [53:36] humidity, [69:54] status_word, [71:70] zero
    logic [0:0]  m_tuser;            // [0] result_code

    // decoder model state, mirrors the block from reset onwards
    logic [3:0]  frame_pos      = 4'd0;
    logic [7:0]  crc_acc        = CRC_INIT;
    logic [7:0]  hi_byte        = 8'h00;
    logic [15:0] co2_raw        = 16'h0000;
    logic [15:0] temp_raw       = 16'h0000;
    logic [15:0] humid_raw      = 16'h0000;
    logic [15:0] status_raw     = 16'h0000;
    logic        crc_bad_seen   = 1'b0;
    logic [1:0]  first_bad_word = 2'd0;

    sensor_reading_t decoded_frames[$];

    int unsigned words_sent     = 0;
    int unsigned mismatch_count = 0;
    int          send_idle_pct  = 0;
    int          stall_pct      = 0;
    int          ready_hold     = 0;

    gas_sensor_frame_decoder u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Generous ceiling on the run time; reaching it reports a failure.
    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------
    // Decoder model
    // ------------------------------------------------------------------

    // Advance the CRC-8 (poly 0x31) by one byte, MSB first.
    function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        repeat (8) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

    // Scale a raw 16-bit reading: round(span * raw / 65535) - base, kept to 18 bits.
    function automatic logic signed [17:0] scale_reading(input logic [15:0] raw,
                                                          input longint span,
                                                          input longint base);
        longint v;
        v = (span * longint'(raw) + 32767) / 65535 - base;
        return v[17:0];
    endfunction

    // Step the model by one accepted byte; queue a reading when a frame completes.
    task automatic decode_rx_byte(input logic [7:0] b, input logic start);
        int unsigned     pos;
        logic [1:0]      widx;
        phase_t          ph;
        logic [15:0]     w;
        sensor_reading_t r;
        pos = 32'(frame_pos);
        if (start) begin
            // resync: drop any partial frame and its error state
            pos = 0;
            crc_bad_seen = 1'b0;
            first_bad_word = 2'd0;
        end
        if (pos >= FRAME_BYTES) begin
            pos = 0;
        end
        widx = 2'(pos / 3);
        ph = phase_t'(2'(pos % 3));
        case (ph)
            PH_HIGH: begin
                crc_acc = crc8_next(CRC_INIT, b);
                hi_byte = b;
            end
            PH_LOW: begin
                w = {hi_byte, b};
                crc_acc = crc8_next(crc_acc, b);
                case (widx)
                    WORD_CO2:   co2_raw = w;
                    WORD_TEMP:  temp_raw = w;
                    WORD_HUMID: humid_raw = w;
                    default:    status_raw = w;
                endcase
            end
            default: begin
                // only the first failing value is remembered
                if (crc_acc != b && !crc_bad_seen) begin
                    crc_bad_seen = 1'b1;
                    first_bad_word = widx;
                end
            end
        endcase
        if (pos == FRAME_BYTES - 1) begin
            r.crc_error = crc_bad_seen;
            if (crc_bad_seen) begin
                // a failed frame carries zeroed values
                r.bad_word   = first_bad_word;
                r.co2_ppm    = '0;
                r.temp_mdegc = '0;
                r.humid_mpct = '0;
                r.status     = '0;
            end else begin
                r.bad_word   = 2'd0;
                r.co2_ppm    = co2_raw;
                r.temp_mdegc = scale_reading(temp_raw, TEMP_SPAN_MDEG, TEMP_BASE_MDEG);
                r.humid_mpct = scale_reading(humid_raw, HUMID_SPAN_MPC, HUMID_BASE_MPC);
                r.status     = status_raw;
            end
            decoded_frames.push_back(r);
            frame_pos = 4'd0;
            crc_bad_seen = 1'b0;
            first_bad_word = 2'd0;
        end else begin
            frame_pos = 4'(pos + 1);
        end
    endtask

    // ------------------------------------------------------------------
    // Channel drivers and result checking
    // ------------------------------------------------------------------

    task automatic flag_mismatch(input string msg);
        $display("mismatch at %0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    // Offer one input word, idling first at random; return after the accepting edge.
    task automatic send_word(input logic [7:0] b, input logic start);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= start;
        // sample ready mid-cycle, where it is stable, then take the edge that accepts
        @(negedge aclk);
        while (!s_tready) begin
            @(negedge aclk);
        end
        @(posedge aclk);
        decode_rx_byte(b, start);
        words_sent++;
    endtask

    // Hold the input idle until every forecast reading has been taken.
    task automatic wait_for_readings();
        s_tvalid <= 1'b0;
        do begin
            @(posedge aclk);
        end while (decoded_frames.size() != 0);
    endtask

    // Send the first len bytes of a frame built from four 16-bit values;
    // corrupt the CRC byte of each value flagged in bad.
    task automatic send_frame(input logic [15:0] vals[4], input logic [3:0] bad,
                              input logic mark, input int len);
        logic [7:0] fb[12];
        logic [7:0] c;
        for (int w = 0; w < 4; w++) begin
            c = crc8_next(crc8_next(CRC_INIT, vals[w][15:8]), vals[w][7:0]);
            if (bad[w]) begin
                c = c ^ 8'($urandom_range(1, 255));
            end
            fb[3*w]     = vals[w][15:8];
            fb[3*w + 1] = vals[w][7:0];
            fb[3*w + 2] = c;
        end
        for (int i = 0; i < len; i++) begin
            send_word(fb[i], mark && (i == 0));
        end
    endtask

    // Mostly random values, with the range ends and the sign boundary mixed in.
    function automatic logic [15:0] pick_value();
        case ($urandom_range(19))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h8000;
            3:       return 16'h7FFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Receiver: stall at random, or hold off for a counted stretch on request.
    always @(posedge aclk) begin
        if (ready_hold > 0) begin
            m_tready   <= 1'b0;
            ready_hold <= ready_hold - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Compare each word taken on the result channel with the oldest forecast.
    always @(negedge aclk) begin : check_readings
        sensor_reading_t want;
        logic signed [15:0] got_co2;
        logic signed [17:0] got_temp;
        logic signed [17:0] got_humid;
        if (aresetn && m_tvalid && m_tready) begin
            if (decoded_frames.size() == 0) begin
                flag_mismatch("result word with no frame pending");
            end else begin
                want      = decoded_frames.pop_front();
                got_co2   = m_tdata[17:2];
                got_temp  = m_tdata[35:18];
                got_humid = m_tdata[53:36];
                if (m_tuser[0] !== want.crc_error) begin
                    flag_mismatch($sformatf("result_code %0b, want %0b",
                                            m_tuser[0], want.crc_error));
                end
                if (m_tdata[1:0] !== want.bad_word) begin
                    flag_mismatch($sformatf("bad_word %0d, want %0d",
                                            m_tdata[1:0], want.bad_word));
                end
                if (got_co2 !== want.co2_ppm) begin
                    flag_mismatch($sformatf("co2_ppm %0d, want %0d", got_co2, want.co2_ppm));
                end
                if (got_temp !== want.temp_mdegc) begin
                    flag_mismatch($sformatf("temperature %0d, want %0d",
                                            got_temp, want.temp_mdegc));
                end
                if (got_humid !== want.humid_mpct) begin
                    flag_mismatch($sformatf("humidity %0d, want %0d",
                                            got_humid, want.humid_mpct));
                end
                if (m_tdata[69:54] !== want.status) begin
                    flag_mismatch($sformatf("status_word %h, want %h",
                                            m_tdata[69:54], want.status));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Unmarked first frame after reset at the range ends, two stray bytes, then a
    // marked frame mid-position whose third and fourth CRCs fail.
    task automatic test_directed_frames();
        logic [15:0] vals[4];
        send_idle_pct = 0;
        stall_pct = 0;
        vals = '{16'h8000, 16'hFFFF, 16'h0000, 16'hFFFF};
        send_frame(vals, 4'b0000, 1'b0, 12);
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b0);
        vals = '{16'h7FFF, 16'h0000, 16'hFFFF, 16'h0000};
        send_frame(vals, 4'b1100, 1'b1, 12);
        wait_for_readings();
    endtask

    // Well-formed frames with random content dominate; truncated frames and
    // noise with random start marks make up the rest.
    task automatic test_mixed_traffic(input int n_words, input int idle_pct, input int stall);
        int unsigned first_count;
        int unsigned pick;
        logic [15:0] vals[4];
        logic [3:0]  bad;
        logic        mark;
        send_idle_pct = idle_pct;
        stall_pct = stall;
        first_count = words_sent;
        while (words_sent - first_count < n_words) begin
            pick = $urandom_range(99);
            for (int i = 0; i < 4; i++) begin
                vals[i] = pick_value();
                bad[i] = ($urandom_range(9) == 0);
            end
            // a mark is optional only when the frame position has wrapped to zero
            mark = (frame_pos != 4'd0) || ($urandom_range(1) == 1);
            if (pick < 70) begin
                send_frame(vals, bad, mark, 12);
            end else if (pick < 85) begin
                send_frame(vals, bad, 1'b1, $urandom_range(1, 11));
            end else begin
                repeat ($urandom_range(1, 8)) begin
                    send_word(8'($urandom), ($urandom_range(3) == 0));
                end
            end
        end
        wait_for_readings();
    endtask

    // Hold the result channel off while frames keep coming, so the block fills
    // and stalls its input; then pause until every reading has drained.
    task automatic test_output_hold_off();
        logic [15:0] vals[4];
        send_idle_pct = 0;
        stall_pct = 0;
        ready_hold <= 300;
        repeat (4) begin
            for (int i = 0; i < 4; i++) begin
                vals[i] = pick_value();
            end
            send_frame(vals, 4'b0000, 1'b1, 12);
        end
        wait_for_readings();
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_frames();
        test_mixed_traffic(450, 0, 0);
        test_output_hold_off();
        test_mixed_traffic(450, 83, 0);
        test_mixed_traffic(450, 0, 83);
        test_mixed_traffic(450, 18, 18);

        wait_for_readings();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
